[rtl/sadcma_pkg.sv]
`timescale 1ns / 1ps

package sadcma_pkg;

  localparam int SAMPLE_W  = 10;
  localparam int CHAN_W    = 3;
  localparam int SUM_W     = 15;
  localparam int WLEN_W    = 8;
  localparam int CFG_W     = 64;
  localparam int MASK_W    = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTHS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_MASK      = 1'd1;

  localparam logic [CFG_W-1:0]  WINDOW_LENGTHS_RESET = '0;
  localparam logic [MASK_W-1:0] SCAN_MASK_RESET      = 8'hFF;

  typedef struct packed {
    logic [CHAN_W-1:0]   chan;
    logic [SAMPLE_W-1:0] sample;
    logic                averaged;
    logic [CHAN_W-1:0]   next_chan;
  } item_t;

endpackage

[rtl/sadcma_fifo.sv]
`timescale 1ns / 1ps

module sadcma_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       count_q;

  assign full_o     = (count_q == 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_data_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

[rtl/sadcma_front.sv]
`timescale 1ns / 1ps

module sadcma_front #(
  parameter int CHANNELS     = 8,
  parameter int WINDOW_DEPTH = 32,
  localparam int CW = $clog2(CHANNELS),
  localparam int HW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sadcma_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sadcma_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                              accept_i,
  input  logic [sadcma_pkg::SAMPLE_W-1:0]   sample_i,
  output sadcma_pkg::item_t                 item_o,
  output logic [HW-1:0]                     head_o
);

  logic [sadcma_pkg::CFG_W-1:0]  wlen_q;
  logic [sadcma_pkg::MASK_W-1:0] mask_q;
  logic [CW-1:0]                 cur_q;
  logic [HW-1:0]                 heads_q [CHANNELS];

  logic [sadcma_pkg::WLEN_W-1:0] raw_len;
  logic [sadcma_pkg::WLEN_W-1:0] len;
  logic                          averaged;
  logic [HW-1:0]                 head_d;
  logic [CW-1:0]                 nxt;
  logic [CW:0]                   cand;

  always_comb begin
    raw_len = wlen_q[sadcma_pkg::WLEN_W*cur_q +: sadcma_pkg::WLEN_W];
    if (raw_len > sadcma_pkg::WLEN_W'(WINDOW_DEPTH)) begin
      len = sadcma_pkg::WLEN_W'(WINDOW_DEPTH);
    end else begin
      len = raw_len;
    end
    averaged = (len != '0);
    if ((9'(heads_q[cur_q]) + 9'd1) >= 9'(len)) begin
      head_d = '0;
    end else begin
      head_d = heads_q[cur_q] + HW'(1);
    end
  end

  always_comb begin
    nxt  = cur_q;
    cand = '0;
    for (int k = CHANNELS; k >= 1; k--) begin
      cand = (CW+1)'(cur_q) + (CW+1)'(k);
      if (cand >= (CW+1)'(CHANNELS)) begin
        cand = cand - (CW+1)'(CHANNELS);
      end
      if (mask_q[cand[CW-1:0]]) begin
        nxt = cand[CW-1:0];
      end
    end
  end

  always_comb begin
    item_o.chan      = sadcma_pkg::CHAN_W'(cur_q);
    item_o.sample    = sample_i;
    item_o.averaged  = averaged;
    item_o.next_chan = sadcma_pkg::CHAN_W'(nxt);
    head_o           = head_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= sadcma_pkg::WINDOW_LENGTHS_RESET;
      mask_q <= sadcma_pkg::SCAN_MASK_RESET;
      cur_q  <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        heads_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sadcma_pkg::REG_WINDOW_LENGTHS: wlen_q <= cfg_data_i;
          sadcma_pkg::REG_SCAN_MASK:      mask_q <= cfg_data_i[sadcma_pkg::MASK_W-1:0];
          default: ;
        endcase
      end
      if (accept_i) begin
        cur_q <= nxt;
        if (averaged) begin
          heads_q[cur_q] <= head_d;
        end
      end
    end
  end

endmodule

[rtl/sadcma_back.sv]
`timescale 1ns / 1ps

module sadcma_back #(
  parameter int CHANNELS     = 8,
  parameter int WINDOW_DEPTH = 32,
  localparam int CW = $clog2(CHANNELS),
  localparam int HW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1,
  localparam int RING_SIZE = CHANNELS * WINDOW_DEPTH,
  localparam int AW = $clog2(RING_SIZE),
  localparam int SW = $clog2(WINDOW_DEPTH * 1023 + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  output logic                              busy_o,
  input  logic                              q_valid_i,
  input  sadcma_pkg::item_t                 q_item_i,
  input  logic [HW-1:0]                     q_head_i,
  output logic                              q_pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [sadcma_pkg::CHAN_W-1:0]     sampled_channel_o,
  output logic [sadcma_pkg::SUM_W-1:0]      window_sum_o,
  output logic                              averaged_o,
  output logic [sadcma_pkg::CHAN_W-1:0]     next_channel_o
);

  logic [sadcma_pkg::SAMPLE_W-1:0] ring_q [RING_SIZE];
  logic [sadcma_pkg::SAMPLE_W-1:0] rd_q;
  logic [SW-1:0]                   sums_q [CHANNELS];

  logic                            busy_q;
  logic [AW-1:0]                   clr_cnt_q;

  logic                            s2_valid_q;
  sadcma_pkg::item_t               s2_item_q;
  logic [AW-1:0]                   s2_addr_q;

  logic                            fwd_valid_q;
  logic [AW-1:0]                   fwd_addr_q;
  logic [sadcma_pkg::SAMPLE_W-1:0] fwd_data_q;

  logic                            out_valid_q;
  logic [sadcma_pkg::CHAN_W-1:0]   out_chan_q;
  logic [SW-1:0]                   out_sum_q;
  logic                            out_avg_q;
  logic [sadcma_pkg::CHAN_W-1:0]   out_next_q;

  logic                            s2_fire;
  logic                            pop;
  logic [AW-1:0]                   rd_addr;
  logic [sadcma_pkg::SAMPLE_W-1:0] old_val;
  logic [SW-1:0]                   new_sum;
  logic                            mem_we;
  logic [AW-1:0]                   mem_waddr;
  logic [sadcma_pkg::SAMPLE_W-1:0] mem_wdata;
  logic [CW-1:0]                   s2_ch;

  assign s2_fire = s2_valid_q && (!out_valid_q || out_ready_i);
  assign pop     = q_valid_i && (!s2_valid_q || s2_fire);
  assign q_pop_o = pop;
  assign busy_o  = busy_q;
  assign s2_ch   = s2_item_q.chan[CW-1:0];
  assign rd_addr = AW'(AW'(q_item_i.chan[CW-1:0]) * AW'(WINDOW_DEPTH)) + AW'(q_head_i);

  always_comb begin
    if (fwd_valid_q && (fwd_addr_q == s2_addr_q)) begin
      old_val = fwd_data_q;
    end else begin
      old_val = rd_q;
    end
    new_sum = sums_q[s2_ch] - SW'(old_val) + SW'(s2_item_q.sample);
    if (busy_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = '0;
    end else begin
      mem_we    = s2_fire && s2_item_q.averaged;
      mem_waddr = s2_addr_q;
      mem_wdata = s2_item_q.sample;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_q[mem_waddr] <= mem_wdata;
    end
    if (pop) begin
      rd_q <= ring_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s2_item_q <= q_item_i;
      s2_addr_q <= rd_addr;
    end
    if (s2_fire) begin
      out_chan_q <= s2_item_q.chan;
      out_sum_q  <= s2_item_q.averaged ? new_sum : '0;
      out_avg_q  <= s2_item_q.averaged;
      out_next_q <= s2_item_q.next_chan;
      if (s2_item_q.averaged) begin
        fwd_addr_q <= s2_addr_q;
        fwd_data_q <= s2_item_q.sample;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b1;
      clr_cnt_q   <= '0;
      s2_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        sums_q[i] <= '0;
      end
    end else begin
      if (busy_q) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(RING_SIZE - 1)) begin
          busy_q <= 1'b0;
        end
      end
      if (pop) begin
        s2_valid_q <= 1'b1;
      end else if (s2_fire) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_fire) begin
        out_valid_q <= 1'b1;
        if (s2_item_q.averaged) begin
          sums_q[s2_ch] <= new_sum;
          fwd_valid_q   <= 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign sampled_channel_o = out_chan_q;
  assign window_sum_o      = sadcma_pkg::SUM_W'(out_sum_q);
  assign averaged_o        = out_avg_q;
  assign next_channel_o    = out_next_q;

endmodule

[rtl/scanned_adc_moving_average.sv]
`timescale 1ns / 1ps
// A result passes the sample queue, the second stage and the output register.
// Throughput: one sample per cycle while the output is ready, set by the single
// read-modify-write of the ring memory per sample, with the last write forwarded to
// the following read. Reset clears control state and sums; a clearing pass then zeroes
// the ring memory, during which no sample is accepted. Configuration writes are taken.

module scanned_adc_moving_average #(
  parameter int CHANNELS     = 8,
  parameter int WINDOW_DEPTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sadcma_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sadcma_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                              sample_valid_i,
  output logic                              sample_ready_o,
  input  logic [sadcma_pkg::SAMPLE_W-1:0]   sample_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [sadcma_pkg::CHAN_W-1:0]     sampled_channel_o,
  output logic [sadcma_pkg::SUM_W-1:0]      window_sum_o,
  output logic                              averaged_o,
  output logic [sadcma_pkg::CHAN_W-1:0]     next_channel_o
);

  localparam int HW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int QW = $bits(sadcma_pkg::item_t) + HW;

  logic              accept;
  logic              busy;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  sadcma_pkg::item_t f_item;
  logic [HW-1:0]     f_head;
  logic [QW-1:0]     q_data;
  sadcma_pkg::item_t b_item;
  logic [HW-1:0]     b_head;

  assign sample_ready_o = !q_full && !busy;
  assign accept         = sample_valid_i && sample_ready_o;
  assign b_item         = q_data[QW-1:HW];
  assign b_head         = q_data[HW-1:0];

  sadcma_front #(
    .CHANNELS     (CHANNELS),
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .sample_i   (sample_value_i),
    .item_o     (f_item),
    .head_o     (f_head)
  );

  sadcma_fifo #(
    .WIDTH (QW)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i ({f_item, f_head}),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  sadcma_back #(
    .CHANNELS     (CHANNELS),
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .busy_o            (busy),
    .q_valid_i         (q_valid),
    .q_item_i          (b_item),
    .q_head_i          (b_head),
    .q_pop_o           (q_pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .sampled_channel_o (sampled_channel_o),
    .window_sum_o      (window_sum_o),
    .averaged_o        (averaged_o),
    .next_channel_o    (next_channel_o)
  );

endmodule

[rtl/sadcma_chk.sv]
`timescale 1ns / 1ps

module sadcma_chk #(
  parameter int CHANNELS = 8
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              sample_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [sadcma_pkg::CHAN_W-1:0]     sampled_channel_o,
  input logic [sadcma_pkg::SUM_W-1:0]      window_sum_o,
  input logic                              averaged_o,
  input logic [sadcma_pkg::CHAN_W-1:0]     next_channel_o
);

  logic                          have_prev_q;
  logic [sadcma_pkg::CHAN_W-1:0] prev_next_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      prev_next_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      have_prev_q <= 1'b1;
      prev_next_q <= next_channel_o;
    end
  end

  // A stalled result holds its value until the transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(window_sum_o)
      && $stable(sampled_channel_o) && $stable(next_channel_o))
    else $error("result changed while stalled");

  // A channel without a window reports a zero sum.
  a_zero_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !averaged_o |-> window_sum_o == '0)
    else $error("nonzero sum on a channel that is not averaged");

  // Each sample belongs to the channel that the previous result selected.
  a_scan_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && have_prev_q |-> sampled_channel_o == prev_next_q)
    else $error("sampled channel does not follow the scan");

  // Channel numbers stay within the configured channel count.
  a_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(sampled_channel_o) < CHANNELS) && (32'(next_channel_o) < CHANNELS))
    else $error("channel number out of range");

  // The ring is still being cleared right after reset.
  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !sample_ready_o)
    else $error("sample accepted before the ring was cleared");

endmodule

bind scanned_adc_moving_average sadcma_chk #(
  .CHANNELS (CHANNELS)
) u_sadcma_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .sample_ready_o    (sample_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .sampled_channel_o (sampled_channel_o),
  .window_sum_o      (window_sum_o),
  .averaged_o        (averaged_o),
  .next_channel_o    (next_channel_o)
);

[dv/scanned_adc_moving_average_test.sv]
`timescale 1ns / 1ps

module scanned_adc_moving_average_test;

  localparam int CHANNELS     = 8;
  localparam int WINDOW_DEPTH = 32;
  localparam int STALL_LIMIT  = 2000;

  typedef struct packed {
    logic [sadcma_pkg::CHAN_W-1:0] chan;
    logic [sadcma_pkg::SUM_W-1:0]  sum;
    logic                          averaged;
    logic [sadcma_pkg::CHAN_W-1:0] next_chan;
  } window_result_t;

  class window_sum_board;
    logic [sadcma_pkg::CFG_W-1:0]    lengths;
    logic [sadcma_pkg::MASK_W-1:0]   mask;
    logic [sadcma_pkg::SAMPLE_W-1:0] ring [CHANNELS][WINDOW_DEPTH];
    logic [4:0]                      heads [CHANNELS];
    logic [sadcma_pkg::SUM_W-1:0]    sums [CHANNELS];
    logic [sadcma_pkg::CHAN_W-1:0]   cur;
    window_result_t                  pending [$];
    int                              errors;

    function new();
      lengths = sadcma_pkg::WINDOW_LENGTHS_RESET;
      mask    = sadcma_pkg::SCAN_MASK_RESET;
      foreach (ring[c, s]) ring[c][s] = '0;
      foreach (heads[c]) begin
        heads[c] = '0;
        sums[c]  = '0;
      end
      cur    = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [sadcma_pkg::CFG_IDX_W-1:0] idx,
                            logic [sadcma_pkg::CFG_W-1:0] data);
      case (idx)
        sadcma_pkg::REG_WINDOW_LENGTHS: begin
          lengths = data;
        end
        sadcma_pkg::REG_SCAN_MASK: begin
          mask = data[sadcma_pkg::MASK_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function void take_sample(logic [sadcma_pkg::SAMPLE_W-1:0] value);
      int ch;
      int len;
      int head;
      int k;
      window_result_t r;
      ch  = cur;
      len = lengths[8*ch +: 8];
      if (len > WINDOW_DEPTH) len = WINDOW_DEPTH;
      r.chan     = cur;
      r.sum      = '0;
      r.averaged = 1'b0;
      if (len != 0) begin
        head = heads[ch] + 1;
        if (head >= len) head = 0;
        sums[ch]       = sums[ch] - ring[ch][head] + value;
        ring[ch][head] = value;
        heads[ch]      = 5'(head);
        r.sum          = sums[ch];
        r.averaged     = 1'b1;
      end
      // Scanning downward leaves the nearest enabled channel above the current one, with wrap-around.
      r.next_chan = cur;
      for (k = CHANNELS; k >= 1; k--) begin
        if (mask[(ch + k) % CHANNELS]) r.next_chan = sadcma_pkg::CHAN_W'((ch + k) % CHANNELS);
      end
      cur = r.next_chan;
      pending.push_back(r);
    endfunction

    function void check_output(logic [sadcma_pkg::CHAN_W-1:0] chan,
                               logic [sadcma_pkg::SUM_W-1:0] sum,
                               logic averaged, logic [sadcma_pkg::CHAN_W-1:0] next_chan);
      window_result_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual chan %0d sum %0d %s %0b %s %0d",
                 $time, chan, sum, "averaged", averaged, "next", next_chan);
        return;
      end
      want = pending.pop_front();
      if (chan !== want.chan) begin
        errors++;
        $display("%0t: sampled_channel expected %0d actual %0d", $time, want.chan, chan);
      end
      if (sum !== want.sum) begin
        errors++;
        $display("%0t: window_sum expected %0d actual %0d", $time, want.sum, sum);
      end
      if (averaged !== want.averaged) begin
        errors++;
        $display("%0t: averaged expected %0b actual %0b", $time, want.averaged, averaged);
      end
      if (next_chan !== want.next_chan) begin
        errors++;
        $display("%0t: next_channel expected %0d actual %0d", $time, want.next_chan, next_chan);
      end
    endfunction
  endclass

  logic                             clk_i;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic [sadcma_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [sadcma_pkg::CFG_W-1:0]     cfg_data_i;
  logic                             sample_valid_i;
  logic                             sample_ready_o;
  logic [sadcma_pkg::SAMPLE_W-1:0]  sample_value_i;
  logic                             out_valid_o;
  logic                             out_ready_i;
  logic [sadcma_pkg::CHAN_W-1:0]    sampled_channel_o;
  logic [sadcma_pkg::SUM_W-1:0]     window_sum_o;
  logic                             averaged_o;
  logic [sadcma_pkg::CHAN_W-1:0]    next_channel_o;

  window_sum_board board = new();
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int stall_cycles = 0;

  logic [sadcma_pkg::SAMPLE_W-1:0] opening_values [16] = '{
    10'h3FF, 10'h000, 10'h3FF, 10'h3FF, 10'h000, 10'h155, 10'h2AA, 10'h3FF,
    10'h3FF, 10'h001, 10'h200, 10'h3FF, 10'h000, 10'h3FF, 10'h3FF, 10'h3FF
  };

  scanned_adc_moving_average #(
    .CHANNELS    (CHANNELS),
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .sample_valid_i   (sample_valid_i),
    .sample_ready_o   (sample_ready_o),
    .sample_value_i   (sample_value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .sampled_channel_o(sampled_channel_o),
    .window_sum_o     (window_sum_o),
    .averaged_o       (averaged_o),
    .next_channel_o   (next_channel_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_output(sampled_channel_o, window_sum_o, averaged_o, next_channel_o);
    end
  end

  always @(posedge clk_i) begin
    if ((sample_valid_i && sample_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic set_config(logic [sadcma_pkg::CFG_W-1:0] lengths,
                            logic [sadcma_pkg::MASK_W-1:0] mask);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sadcma_pkg::REG_WINDOW_LENGTHS;
    cfg_data_i <= lengths;
    @(posedge clk_i);
    cfg_idx_i  <= sadcma_pkg::REG_SCAN_MASK;
    cfg_data_i <= {{(sadcma_pkg::CFG_W - sadcma_pkg::MASK_W){1'b0}}, mask};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.write_reg(sadcma_pkg::REG_WINDOW_LENGTHS, lengths);
    board.write_reg(sadcma_pkg::REG_SCAN_MASK,
                    {{(sadcma_pkg::CFG_W - sadcma_pkg::MASK_W){1'b0}}, mask});
  endtask

  task automatic send_sample(logic [sadcma_pkg::SAMPLE_W-1:0] value);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      sample_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    sample_valid_i <= 1'b1;
    sample_value_i <= value;
    do @(posedge clk_i); while (!sample_ready_o);
    board.take_sample(value);
  endtask

  task automatic drain();
    sample_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_window();
    case ($urandom_range(0, 6))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd2;
      3: return 8'd32;
      4: return 8'd255;
      5: return 8'($urandom_range(33, 254));
      default: return 8'($urandom_range(3, 31));
    endcase
  endfunction

  initial begin
    logic [sadcma_pkg::CFG_W-1:0]    lengths;
    logic [sadcma_pkg::MASK_W-1:0]   mask;
    logic [sadcma_pkg::SAMPLE_W-1:0] value;
    int                              count;
    bit                              saturate;
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= '0;
    cfg_data_i     <= '0;
    sample_valid_i <= 1'b0;
    sample_value_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_config(64'h0120_21FF_0302_0100, 8'hFF);
    foreach (opening_values[i]) send_sample(opening_values[i]);
    drain();
    set_config('1, 8'h00);
    repeat (3) send_sample(10'h3FF);
    drain();
    set_config(64'h0000_0100_0000_0001, 8'h20);
    send_sample(10'h000);
    send_sample(10'h3FF);
    send_sample(10'h123);
    send_sample(10'h2DC);
    drain();

    for (int p = 0; p < 12; p++) begin
      saturate = (p == 3);
      if (saturate) begin
        lengths = '1;
        mask    = 8'h01 << $urandom_range(0, 7);
      end else if (p == 6) begin
        lengths = '0;
        mask    = 8'($urandom);
      end else begin
        for (int c = 0; c < CHANNELS; c++) lengths[8*c +: 8] = pick_window();
        case ($urandom_range(0, 5))
          0: mask = 8'h00;
          1: mask = 8'hFF;
          2: mask = 8'h01 << $urandom_range(0, 7);
          default: mask = 8'($urandom);
        endcase
      end
      tx_idle_on = (p < 11) && ($urandom_range(0, 3) != 0);
      rx_idle_on = (p < 11) && ($urandom_range(0, 3) != 0);
      set_config(lengths, mask);
      count = $urandom_range(40, 56);
      repeat (count) begin
        if (saturate) begin
          value = 10'h3FF;
        end else if ($urandom_range(0, 3) == 0) begin
          value = $urandom_range(0, 1) ? 10'h3FF : 10'h000;
        end else begin
          value = 10'($urandom_range(0, 1023));
        end
        send_sample(value);
      end
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
